// ===== rtl/core/pntt_pkg.sv =====
// shared types, codes and constants for the periodic next trigger time block
// no dependencies; every other file refers to this package by scoped names
package pntt_pkg;

	localparam int TW = 64;
	localparam int PW = TW - 1;
	localparam int KW = 3;
	localparam int IW = 2;

	// result kind decided in the front stage
	localparam logic [KW-1:0] K_NONE  = 3'd0;
	localparam logic [KW-1:0] K_NEVER = 3'd1;
	localparam logic [KW-1:0] K_START = 3'd2;
	localparam logic [KW-1:0] K_FWD   = 3'd3;
	localparam logic [KW-1:0] K_BEND  = 3'd4;
	localparam logic [KW-1:0] K_BIN   = 3'd5;

	// configuration register indexes
	localparam logic [IW-1:0] REG_REPEAT = 2'd0;
	localparam logic [IW-1:0] REG_START  = 2'd1;
	localparam logic [IW-1:0] REG_END    = 2'd2;
	localparam logic [IW-1:0] REG_PERIOD = 2'd3;

	localparam logic [TW-1:0] T_NEVER = {1'b0, {(TW - 1){1'b1}}};

	typedef struct packed {
		logic          rep_on;
		logic [TW-1:0] st;
		logic [TW-1:0] tend;
		logic [PW-1:0] p;
	} cfg_t;

	typedef struct packed {
		logic [KW-1:0] kind;
		logic [TW-1:0] d;
	} side_t;

	typedef struct packed {
		logic [PW-1:0] rem;
		side_t         side;
	} cell_t;

	typedef struct packed {
		logic [TW-1:0] next_time;
		logic          never;
		logic          updated;
	} res_t;

endpackage

// ===== rtl/core/pntt_front.sv =====
// front stage: classifies the transaction and picks the dividend for the cell chain
// depends on pntt_pkg
module pntt_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   vin,
	input  logic [pntt_pkg::TW-1:0] cur,
	input  logic                   fwd,
	input  pntt_pkg::cfg_t         cfg,
	output logic                   vout,
	output pntt_pkg::side_t        side
);

	logic                    end_lt_cur;
	logic                    cur_lt_st;
	logic                    end_lt_st;
	logic [pntt_pkg::TW-1:0] d_cur;
	logic [pntt_pkg::TW-1:0] d_end;
	logic [pntt_pkg::TW-1:0] st_m_end;
	logic                    gap_short;
	pntt_pkg::side_t         nxt;
	logic                    v_s1;
	pntt_pkg::side_t         side_s1;

	always_comb begin
		end_lt_cur = $signed(cfg.tend) < $signed(cur);
		cur_lt_st  = $signed(cur) < $signed(cfg.st);
		end_lt_st  = $signed(cfg.tend) < $signed(cfg.st);
		d_cur      = cur - cfg.st;
		d_end      = cfg.tend - cfg.st;
		st_m_end   = cfg.st - cfg.tend;
		gap_short  = st_m_end < {1'b0, cfg.p};
		nxt.d      = d_cur;
		nxt.kind   = pntt_pkg::K_NEVER;
		if (!cfg.rep_on) begin
			nxt.kind = pntt_pkg::K_NONE;
		end else if (cfg.p == '0) begin
			nxt.kind = pntt_pkg::K_NEVER;
		end else if (fwd) begin
			if (end_lt_cur) begin
				nxt.kind = pntt_pkg::K_NEVER;
			end else if (!cur_lt_st) begin
				nxt.kind = pntt_pkg::K_FWD;
			end else if (end_lt_st) begin
				nxt.kind = pntt_pkg::K_NEVER;
			end else begin
				nxt.kind = pntt_pkg::K_START;
			end
		end else begin
			if (cur_lt_st) begin
				nxt.kind = pntt_pkg::K_NEVER;
			end else if (end_lt_cur) begin
				if (!end_lt_st) begin
					nxt.kind = pntt_pkg::K_BEND;
					nxt.d    = d_end;
				end else if (gap_short) begin
					nxt.kind = pntt_pkg::K_START;
				end else begin
					nxt.kind = pntt_pkg::K_NEVER;
				end
			end else if (d_cur == '0) begin
				nxt.kind = pntt_pkg::K_NEVER;
			end else begin
				nxt.kind = pntt_pkg::K_BIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= nxt;
		end
	end

	assign vout = v_s1;
	assign side = side_s1;

endmodule

// ===== rtl/core/pntt_cell.sv =====
// one restoring division cell: shifts in one dividend bit and subtracts the period
// depends on pntt_pkg
module pntt_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   vin,
	input  pntt_pkg::cell_t        din,
	input  logic                   dbit,
	input  logic [pntt_pkg::PW-1:0] p,
	output logic                   vout,
	output pntt_pkg::cell_t        dout
);

	logic [pntt_pkg::TW-1:0] trial;
	logic [pntt_pkg::TW-1:0] diff;
	logic                    ge;
	pntt_pkg::cell_t         nxt;
	logic                    v_q;
	pntt_pkg::cell_t         d_q;

	always_comb begin
		trial    = {din.rem, dbit};
		diff     = trial - {1'b0, p};
		ge       = trial >= {1'b0, p};
		nxt.side = din.side;
		nxt.rem  = ge ? diff[pntt_pkg::PW-1:0] : trial[pntt_pkg::PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q <= nxt;
		end
	end

	assign vout = v_q;
	assign dout = d_q;

endmodule

// ===== rtl/core/pntt_post.sv =====
// back end: turns the remainder into the grid offset and forms the trigger time
// depends on pntt_pkg
module pntt_post (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   vin,
	input  pntt_pkg::cell_t        din,
	input  pntt_pkg::cfg_t         cfg,
	input  logic [pntt_pkg::TW-1:0] span,
	output logic                   vout,
	output pntt_pkg::res_t         res
);

	logic                         v_s1;
	logic [pntt_pkg::KW-1:0]      kind_s1;
	logic [pntt_pkg::TW-1:0]      q_s1;
	logic                         zr_s1;
	logic                         v_s2;
	logic [pntt_pkg::KW-1:0]      kind_s2;
	logic [pntt_pkg::TW:0]        off_s2;
	logic [pntt_pkg::TW:0]        off_nxt;
	logic [pntt_pkg::TW-1:0]      back_p;
	logic [pntt_pkg::TW-1:0]      sum;

	// grid point at or below the dividend
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= din.side.kind;
			q_s1    <= din.side.d - {1'b0, din.rem};
			zr_s1   <= din.rem == '0;
		end
	end

	// exact hit in backward time steps one period further back
	always_comb begin
		back_p = zr_s1 ? {1'b0, cfg.p} : '0;
		case (kind_s1)
			pntt_pkg::K_FWD: off_nxt = {1'b0, q_s1} + {2'b0, cfg.p};
			pntt_pkg::K_BIN: off_nxt = {1'b0, q_s1 - back_p};
			default:         off_nxt = {1'b0, q_s1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			off_s2  <= off_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		sum = cfg.st + off_s2[pntt_pkg::TW-1:0];
		res = '{next_time: sum, never: 1'b0, updated: 1'b1};
		case (kind_s2)
			pntt_pkg::K_NONE: begin
				res = '{next_time: '0, never: 1'b0, updated: 1'b0};
			end
			pntt_pkg::K_NEVER: begin
				res = '{next_time: pntt_pkg::T_NEVER, never: 1'b1, updated: 1'b1};
			end
			pntt_pkg::K_START: begin
				res.next_time = cfg.st;
			end
			pntt_pkg::K_FWD: begin
				if (off_s2[pntt_pkg::TW] || (off_s2[pntt_pkg::TW-1:0] > span)) begin
					res = '{next_time: pntt_pkg::T_NEVER, never: 1'b1, updated: 1'b1};
				end
			end
			default: begin
				res.next_time = sum;
			end
		endcase
	end

	assign vout = v_s2;

endmodule

// ===== rtl/core/periodic_next_trigger_time_top.sv =====
// periodic next trigger time: front stage, chain of division cells, back end, output skid
// depends on pntt_pkg, pntt_front, pntt_cell, pntt_post
// path to m_axis_tvalid: front register, cell registers, back-end registers, output register
// one transaction per cycle while not stalled; one division cell per dividend bit (64 cells)
// a stalled output holds one result plus one in the skid register before s_axis_tready drops
// arst_n clears all valid bits and loads has_repeat 0, start 0, end 0, period 1
module periodic_next_trigger_time_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [pntt_pkg::TW-1:0]        s_axis_tdata,  // current_time
	input  logic [0:0]                     s_axis_tuser,  // forward
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [pntt_pkg::TW-1:0]        m_axis_tdata,  // next_time
	output logic [1:0]                     m_axis_tuser,  // bit 1 updated, bit 0 never
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pntt_pkg::IW-1:0]        cfg_index,
	input  logic [pntt_pkg::TW-1:0]        cfg_data
);

	pntt_pkg::cfg_t          cfg_q;
	logic [pntt_pkg::TW-1:0] span_q;
	logic                    adv;
	logic                    front_v;
	pntt_pkg::side_t         front_side;
	logic                    chain_v [0:pntt_pkg::TW];
	pntt_pkg::cell_t         chain_d [0:pntt_pkg::TW];
	logic                    post_v;
	pntt_pkg::res_t          post_res;
	logic                    out_valid_q;
	pntt_pkg::res_t          out_q;
	logic                    skid_full_q;
	pntt_pkg::res_t          skid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rep_on: 1'b0, st: '0, tend: '0, p: {{(pntt_pkg::PW - 1){1'b0}}, 1'b1}};
		end else if (cfg_valid) begin
			case (cfg_index)
				pntt_pkg::REG_REPEAT: cfg_q.rep_on <= cfg_data[0];
				pntt_pkg::REG_START:  cfg_q.st     <= cfg_data;
				pntt_pkg::REG_END:    cfg_q.tend   <= cfg_data;
				pntt_pkg::REG_PERIOD: cfg_q.p      <= cfg_data[pntt_pkg::PW-1:0];
				default: ;
			endcase
		end
	end

	// window length, settled long before any transaction reaches the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= '0;
		end else begin
			span_q <= cfg_q.tend - cfg_q.st;
		end
	end

	// the whole chain moves while the skid register is free
	assign adv           = !skid_full_q;
	assign s_axis_tready = !skid_full_q;

	pntt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (s_axis_tvalid),
		.cur    (s_axis_tdata),
		.fwd    (s_axis_tuser[0]),
		.cfg    (cfg_q),
		.vout   (front_v),
		.side   (front_side)
	);

	assign chain_v[0] = front_v;
	assign chain_d[0] = '{rem: '0, side: front_side};

	for (genvar i = 0; i < pntt_pkg::TW; i++) begin : g_cell
		pntt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vin    (chain_v[i]),
			.din    (chain_d[i]),
			.dbit   (chain_d[i].side.d[pntt_pkg::TW-1-i]),
			.p      (cfg_q.p),
			.vout   (chain_v[i+1]),
			.dout   (chain_d[i+1])
		);
	end

	pntt_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (chain_v[pntt_pkg::TW]),
		.din    (chain_d[pntt_pkg::TW]),
		.cfg    (cfg_q),
		.span   (span_q),
		.vout   (post_v),
		.res    (post_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (m_axis_tready) begin
				skid_full_q <= 1'b0;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= post_v;
		end else if (post_v) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (m_axis_tready) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			if (post_v) begin
				out_q <= post_res;
			end
		end else if (post_v) begin
			skid_q <= post_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.next_time;
	assign m_axis_tuser  = {out_q.updated, out_q.never};

endmodule

// ===== rtl/core/pntt_chk.sv =====
// port-level checks for the periodic next trigger time block, bound to the top level
// depends on pntt_pkg and periodic_next_trigger_time_top
module pntt_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_axis_tready,
	input logic                    m_axis_tvalid,
	input logic                    m_axis_tready,
	input logic [pntt_pkg::TW-1:0] m_axis_tdata,
	input logic [1:0]              m_axis_tuser
);

	// a waiting result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// input side only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no pending result");

	a_stall_start: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stall began without output backpressure");

	// a never result carries the largest time, a skipped one carries zeros
	a_result_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tuser[1] || (!m_axis_tuser[0] && m_axis_tdata == '0)) &&
			(!m_axis_tuser[0] || (m_axis_tuser[1] && m_axis_tdata == pntt_pkg::T_NEVER)))
		else $error("inconsistent never/updated result");

endmodule

bind periodic_next_trigger_time_top pntt_chk u_pntt_chk (.*);

// ===== sim/tb.sv =====
// testbench for periodic_next_trigger_time_top: directed and random trigger-time checks
// drives the stream and configuration ports, predicts each result in a local model
// depends on pntt_pkg and the rtl of periodic_next_trigger_time_top
`timescale 1ns / 100ps

module tb;

	localparam logic [63:0] T_MIN    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] T_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PER_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          RANDOM_ITEMS  = 1300;
	localparam int          SETTLE_CYCLES = 100;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [pntt_pkg::TW-1:0]      s_axis_tdata = '0;   // current_time
	logic [0:0]                   s_axis_tuser = '0;   // forward
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b1;
	logic [pntt_pkg::TW-1:0]      m_axis_tdata;        // next_time
	logic [1:0]                   m_axis_tuser;        // bit 1 updated, bit 0 never
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [pntt_pkg::IW-1:0]      cfg_index = '0;
	logic [pntt_pkg::TW-1:0]      cfg_data = '0;

	// local copy of the window registers
	logic                         rep_on = 1'b0;
	logic [63:0]                  win_start = '0;
	logic [63:0]                  win_end = '0;
	logic [62:0]                  win_period = 63'd1;

	pntt_pkg::res_t               pending_trig[$];
	int                           mismatches = 0;
	int                           quiet_cycles = 0;
	logic                         tx_idle = 1'b0;
	logic                         rx_idle = 1'b0;

	periodic_next_trigger_time_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic less_s(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	// next trigger time for the current window registers
	function automatic pntt_pkg::res_t next_trigger(input logic [63:0] cur, input logic fwd);
		logic [63:0]    st;
		logic [63:0]    en;
		logic [63:0]    p;
		logic [63:0]    d;
		logic [63:0]    q;
		logic [63:0]    off;
		logic [63:0]    m;
		logic [63:0]    nxt;
		logic           nev;
		pntt_pkg::res_t r;
		st  = win_start;
		en  = win_end;
		p   = {1'b0, win_period};
		nxt = '0;
		nev = 1'b0;
		if (!rep_on) begin
			r.next_time = '0;
			r.never     = 1'b0;
			r.updated   = 1'b0;
			return r;
		end
		if (p == 0) begin
			nev = 1'b1;
		end else if (fwd) begin
			if (less_s(en, cur)) begin
				nev = 1'b1;
			end else if (!less_s(cur, st)) begin
				d   = cur - st;
				q   = (d / p) * p;
				off = q + p;
				// wrap of the offset means the next grid point is unreachable
				if (off < q || off > en - st)
					nev = 1'b1;
				else
					nxt = st + off;
			end else if (less_s(en, st)) begin
				nev = 1'b1;
			end else begin
				nxt = st;
			end
		end else begin
			if (less_s(cur, st)) begin
				nev = 1'b1;
			end else if (less_s(en, cur)) begin
				if (!less_s(en, st)) begin
					d   = en - st;
					nxt = st + (d / p) * p;
				end else if (st - en < p) begin
					nxt = st;
				end else begin
					nev = 1'b1;
				end
			end else begin
				d = cur - st;
				if (d == 0) begin
					nev = 1'b1;
				end else begin
					m = d / p;
					if (d % p == 0)
						m = m - 1;
					nxt = st + m * p;
				end
			end
		end
		if (nev)
			nxt = pntt_pkg::T_NEVER;
		r.next_time = nxt;
		r.never     = nev;
		r.updated   = 1'b1;
		return r;
	endfunction

	task automatic send_time(input logic [63:0] cur, input logic fwd);
		int gap;
		gap = tx_idle ? $urandom_range(17, 0) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cur;
		s_axis_tuser  <= fwd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_trig.push_back(next_trigger(cur, fwd));
	endtask

	// stop sending and wait until every outstanding result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_trig.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pntt_pkg::IW-1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pntt_pkg::REG_REPEAT: rep_on     = data[0];
			pntt_pkg::REG_START:  win_start  = data;
			pntt_pkg::REG_END:    win_end    = data;
			pntt_pkg::REG_PERIOD: win_period = data[62:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic rep, input logic [63:0] st, input logic [63:0] en,
			input logic [63:0] per);
		write_reg(pntt_pkg::REG_REPEAT, {63'd0, rep});
		write_reg(pntt_pkg::REG_START, st);
		write_reg(pntt_pkg::REG_END, en);
		write_reg(pntt_pkg::REG_PERIOD, per);
		cfg_valid <= 1'b0;
	endtask

	// reset values: repeat off, so nothing is recomputed
	task automatic test_repeat_off();
		send_time(T_MIN, 1'b1);
		send_time(T_MAX, 1'b0);
		drain();
	endtask

	task automatic test_forward();
		configure(1'b1, 64'd100, 64'd1000, 64'd7);
		send_time(-64'sd5, 1'b1);
		send_time(64'd100, 1'b1);
		send_time(64'd106, 1'b1);
		send_time(64'd107, 1'b1);
		send_time(64'd995, 1'b1);
		send_time(64'd996, 1'b1);
		send_time(64'd1001, 1'b1);
		drain();
		// window end before its start
		configure(1'b1, 64'd100, 64'd50, 64'd7);
		send_time(64'd0, 1'b1);
		send_time(64'd200, 1'b0);
		drain();
		// end less than one period before start falls back to start
		configure(1'b1, 64'd100, 64'd95, 64'd7);
		send_time(64'd200, 1'b0);
		drain();
	endtask

	task automatic test_backward();
		configure(1'b1, 64'd100, 64'd1000, 64'd7);
		send_time(64'd50, 1'b0);
		send_time(64'd100, 1'b0);
		send_time(64'd101, 1'b0);
		send_time(64'd107, 1'b0);
		send_time(64'd108, 1'b0);
		send_time(64'd2000, 1'b0);
		drain();
	endtask

	task automatic test_extremes();
		// full range window with the largest period: forward step overflows at the top
		configure(1'b1, T_MIN, T_MAX, PER_MAX);
		send_time(T_MAX, 1'b1);
		send_time(T_MIN, 1'b1);
		send_time(T_MAX, 1'b0);
		drain();
		// zero period never triggers
		configure(1'b1, 64'd0, 64'd100, 64'd0);
		send_time(64'd10, 1'b1);
		send_time(64'd10, 1'b0);
		drain();
	endtask

	task automatic test_random_windows();
		logic [63:0] st;
		logic [63:0] en;
		logic [63:0] per;
		logic [63:0] pe;
		logic [63:0] cur;
		logic [63:0] off;
		logic        rep;
		int          sel;
		int          k;
		int          n;
		int          sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			sel = $urandom_range(9, 0);
			if (sel < 5)
				per = 64'($urandom_range(64, 1));
			else if (sel < 7)
				per = 64'($urandom);
			else if (sel == 7)
				per = rand64();
			else if (sel == 8)
				per = PER_MAX;
			else
				per = ($urandom_range(3, 0) == 0) ? 64'd0 : rand64() >> 1;
			pe = {1'b0, per[62:0]};
			st = $urandom_range(1, 0) ? rand64() : 64'($signed($urandom));
			sel = $urandom_range(7, 0);
			if (sel < 6)
				en = st + 64'($urandom_range(40, 0)) * pe + ((pe != 0) ? rand64() % pe : 64'd0);
			else if (sel == 6)
				en = rand64();
			else
				en = st - 64'($urandom_range(3, 0)) * pe - 64'($urandom_range(5, 0));
			rep = $urandom_range(7, 0) != 0;
			configure(rep, st, en, per);
			tx_idle = $urandom_range(3, 0) != 0;
			rx_idle = $urandom_range(3, 0) != 0;
			n = $urandom_range(120, 40);
			repeat (n) begin
				sel = $urandom_range(9, 0);
				if (sel < 2) begin
					cur = rand64();
				end else if (sel == 2) begin
					cur = en + 64'($urandom_range(2, 0)) - 64'd1;
				end else begin
					k = $urandom_range(46, 0) - 3;
					case ($urandom_range(3, 0))
						0: off = 64'd0;
						1: off = 64'd1;
						2: off = pe - 64'd1;
						default: off = (pe != 0) ? rand64() % pe : rand64();
					endcase
					cur = st + 64'(k) * pe + off;
				end
				send_time(cur, 1'($urandom_range(1, 0)));
				sent++;
			end
		end
		drain();
	endtask

	// output side backpressure, drawn per result
	initial begin : result_stalls
		int n;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				n = rx_idle ? $urandom_range(17, 0) : 0;
				if (n > 0) begin
					m_axis_tready <= 1'b0;
					repeat (n) @(posedge clk);
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		pntt_pkg::res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_trig.size() == 0) begin
				$error("result transaction with nothing expected: next_time %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_trig.pop_front();
				if (m_axis_tdata !== want.next_time) begin
					$error("next_time: expected %h, got %h", want.next_time, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser[0] !== want.never) begin
					$error("never: expected %b, got %b", want.never, m_axis_tuser[0]);
					mismatches++;
				end
				if (m_axis_tuser[1] !== want.updated) begin
					$error("updated: expected %b, got %b", want.updated, m_axis_tuser[1]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL periodic_next_trigger_time_top");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_repeat_off();
		test_forward();
		test_backward();
		test_extremes();
		test_random_windows();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_trig.size() == 0)
			$display("PASS periodic_next_trigger_time_top");
		else
			$display("FAIL periodic_next_trigger_time_top");
		$finish;
	end

endmodule
